@@ rtl/core/polygon_point_inside_test_top_defines.svh @@
// assertion macros used by the checker file ppit_checker.sv
`ifndef POLYGON_POINT_INSIDE_TEST_TOP_DEFINES_SVH
`define POLYGON_POINT_INSIDE_TEST_TOP_DEFINES_SVH

// clocked assertion, off while in reset
`define PPIT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ppit check failed");

// antecedent in one cycle, consequent in the next
`define PPIT_ASSERT_NEXT(lbl, ante, cons) \
  `PPIT_ASSERT(lbl, (ante) |=> (cons))

`endif

@@ rtl/core/ppit_pkg.sv @@
package ppit_pkg;

  localparam int MaxVerts = 1024;
  localparam int AddrW    = $clog2(MaxVerts);
  localparam int CntW     = AddrW + 1;
  localparam int FracBits = 8;
  localparam int CoordW   = 32;
  localparam int QueryW   = 24;
  localparam int OutCntW  = 11;
  localparam int OpW      = CoordW + 1;
  localparam int ProdW    = 2 * OpW;
  localparam int FcW      = CoordW + 4;
  localparam int ItW      = $clog2(OpW);
  localparam int VertW    = 2 * CoordW + 1;

  typedef enum logic [1:0] {
    KindLoad  = 2'd0,
    KindQuery = 2'd1,
    KindClear = 2'd2
  } kind_e;

  typedef struct packed {
    logic              last;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
  } vert_t;

  typedef struct packed {
    logic query_start;
    logic load_cur;
    logic mark_start;
    logic step;
    logic edge_sel;
    logic edge_setup;
    logic mul_step;
    logic div_step;
    logic edge_fin;
    logic out_load;
    logic ovf;
  } cmd_t;

  typedef struct packed {
    logic straddle;
    logic ring_last;
  } sts_t;

endpackage

@@ rtl/core/ppit_ram.sv @@
module ppit_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

@@ rtl/core/ppit_ctrl.sv @@
module ppit_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  kind_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        wr_en_o,
  output logic [ppit_pkg::AddrW-1:0]  wr_addr_o,
  output logic                        rd_en_o,
  output logic [ppit_pkg::AddrW-1:0]  rd_addr_o,
  output ppit_pkg::cmd_t              cmd_o,
  input  ppit_pkg::sts_t              sts_i
);

  typedef enum logic [3:0] {
    StIdle,
    StRead,
    StLoad,
    StEdge,
    StMul,
    StDiv,
    StFin,
    StAfter,
    StNext,
    StOut
  } state_e;

  state_e                       state_q;
  logic [ppit_pkg::CntW-1:0]    cnt_q;
  logic                         ovf_q;
  logic [ppit_pkg::AddrW-1:0]   idx_q;
  logic                         first_q;
  logic                         closing_q;
  logic                         sel_q;
  logic [ppit_pkg::ItW-1:0]     it_q;
  logic                         out_valid_q;
  logic                         accept;
  logic                         is_last;
  logic                         out_free;

  assign accept    = in_valid_i && (state_q == StIdle);
  assign is_last   = (ppit_pkg::CntW'(idx_q) + 1'b1) == cnt_q;
  assign out_free  = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign wr_en_o     = accept && (kind_i == ppit_pkg::KindLoad) &&
                       (cnt_q < ppit_pkg::CntW'(ppit_pkg::MaxVerts));
  assign wr_addr_o   = cnt_q[ppit_pkg::AddrW-1:0];
  assign rd_en_o     = (state_q == StRead);
  assign rd_addr_o   = idx_q;

  always_comb begin
    cmd_o             = '0;
    cmd_o.ovf         = ovf_q;
    cmd_o.edge_sel    = sel_q;
    cmd_o.mark_start  = first_q;
    cmd_o.query_start = accept && (kind_i == ppit_pkg::KindQuery);
    cmd_o.load_cur    = (state_q == StLoad);
    cmd_o.edge_setup  = (state_q == StEdge) && sts_i.straddle;
    cmd_o.mul_step    = (state_q == StMul);
    cmd_o.div_step    = (state_q == StDiv);
    cmd_o.edge_fin    = (state_q == StFin);
    cmd_o.step        = (state_q == StNext);
    cmd_o.out_load    = (state_q == StOut) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      first_q     <= 1'b1;
      closing_q   <= 1'b0;
      sel_q       <= 1'b0;
      it_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == StOut) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            unique case (kind_i)
              ppit_pkg::KindLoad: begin
                if (cnt_q < ppit_pkg::CntW'(ppit_pkg::MaxVerts)) begin
                  cnt_q <= cnt_q + 1'b1;
                end else begin
                  ovf_q <= 1'b1;
                end
              end
              ppit_pkg::KindClear: begin
                cnt_q <= '0;
                ovf_q <= 1'b0;
              end
              ppit_pkg::KindQuery: begin
                idx_q   <= '0;
                first_q <= 1'b1;
                state_q <= (cnt_q == '0) ? StOut : StRead;
              end
              default: begin
              end
            endcase
          end
        end
        StRead: begin
          state_q <= StLoad;
        end
        StLoad: begin
          closing_q <= sts_i.ring_last || is_last;
          if (!first_q) begin
            sel_q   <= 1'b0;
            state_q <= StEdge;
          end else if (sts_i.ring_last || is_last) begin
            sel_q   <= 1'b1;
            state_q <= StEdge;
          end else begin
            state_q <= StNext;
          end
        end
        StEdge: begin
          it_q    <= '0;
          state_q <= sts_i.straddle ? StMul : StAfter;
        end
        StMul: begin
          if (it_q == ppit_pkg::ItW'(ppit_pkg::OpW - 1)) begin
            it_q    <= '0;
            state_q <= StDiv;
          end else begin
            it_q <= it_q + 1'b1;
          end
        end
        StDiv: begin
          if (it_q == ppit_pkg::ItW'(ppit_pkg::OpW - 1)) begin
            state_q <= StFin;
          end else begin
            it_q <= it_q + 1'b1;
          end
        end
        StFin: begin
          state_q <= StAfter;
        end
        StAfter: begin
          if (!sel_q && closing_q) begin
            sel_q   <= 1'b1;
            state_q <= StEdge;
          end else begin
            state_q <= StNext;
          end
        end
        StNext: begin
          first_q <= closing_q;
          if (is_last) begin
            state_q <= StOut;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= StRead;
          end
        end
        StOut: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/ppit_dp.sv @@
module ppit_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic signed [ppit_pkg::QueryW-1:0] query_x_i,
  input  logic signed [ppit_pkg::QueryW-1:0] query_y_i,
  input  ppit_pkg::vert_t                  rd_data_i,
  input  ppit_pkg::cmd_t                   cmd_i,
  output ppit_pkg::sts_t                   sts_o,
  output logic                             inside_res_o,
  output logic [ppit_pkg::OutCntW-1:0]     crossing_count_o,
  output logic                             overflow_o
);

  localparam int OpW = ppit_pkg::OpW;
  localparam int FcW = ppit_pkg::FcW;

  logic signed [ppit_pkg::QueryW-1:0] qx_q;
  logic signed [ppit_pkg::CoordW-1:0] yq_q;
  ppit_pkg::vert_t                    cur_q, prev_q, start_q;
  ppit_pkg::vert_t                    va, vb;
  logic [ppit_pkg::OutCntW-1:0]       count_q;

  logic signed [ppit_pkg::CoordW-1:0] x0_q;
  logic                               neg_q;
  logic [OpW-1:0]                     mag_q, mplr_q, dy_q;
  logic [ppit_pkg::ProdW-1:0]         acc_q;

  logic signed [ppit_pkg::CoordW-1:0] ay, by;
  logic signed [OpW-1:0]              x0e, y0e, x1e, y1e, yqe, dxs, dyw, tw;
  logic signed [ppit_pkg::CoordW-1:0] x0s;
  logic [OpW:0]                       r2;
  logic                               ge;
  logic [OpW:0]                       nr;
  logic                               rnz;
  logic signed [FcW-1:0]              x0f, qdf, fc, fl, tr, qxf;
  logic                               hit;

  assign va = cmd_i.edge_sel ? cur_q : prev_q;
  assign vb = cmd_i.edge_sel ? start_q : cur_q;
  assign ay = $signed(va.y);
  assign by = $signed(vb.y);

  assign sts_o.straddle  = (ay > yq_q) != (by > yq_q);
  assign sts_o.ring_last = rd_data_i.last;

  always_comb begin
    if (ay < by) begin
      x0s = $signed(va.x);
      x0e = OpW'($signed(va.x));
      y0e = OpW'(ay);
      x1e = OpW'($signed(vb.x));
      y1e = OpW'(by);
    end else begin
      x0s = $signed(vb.x);
      x0e = OpW'($signed(vb.x));
      y0e = OpW'(by);
      x1e = OpW'($signed(va.x));
      y1e = OpW'(ay);
    end
    yqe = OpW'(yq_q);
    dxs = x1e - x0e;
    dyw = y1e - y0e;
    tw  = yqe - y0e;
  end

  // one restoring division step on the upper half of acc
  assign r2 = {acc_q[ppit_pkg::ProdW-1:OpW], acc_q[OpW-1]};
  assign ge = r2 >= {1'b0, dy_q};
  assign nr = ge ? (r2 - {1'b0, dy_q}) : r2;

  always_comb begin
    rnz = |acc_q[ppit_pkg::ProdW-1:OpW];
    x0f = FcW'(x0_q);
    qdf = $signed(FcW'(acc_q[OpW-1:0]));
    qxf = FcW'(qx_q);
    if (neg_q) begin
      fc = x0f - qdf - FcW'(rnz);
    end else begin
      fc = x0f + qdf;
    end
    fl = rnz ? (-fc - FcW'(1)) : -fc;
    if (!fc[FcW-1]) begin
      tr = fc >>> ppit_pkg::FracBits;
    end else begin
      tr = -(fl >>> ppit_pkg::FracBits);
    end
    hit = tr >= qxf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.query_start) begin
      count_q <= '0;
    end else if (cmd_i.edge_fin && hit) begin
      count_q <= count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.query_start) begin
      qx_q <= query_x_i;
      yq_q <= ppit_pkg::CoordW'(query_y_i) <<< ppit_pkg::FracBits;
    end
    if (cmd_i.load_cur) begin
      cur_q <= rd_data_i;
      if (cmd_i.mark_start) begin
        start_q <= rd_data_i;
      end
    end
    if (cmd_i.step) begin
      prev_q <= cur_q;
    end
    if (cmd_i.edge_setup) begin
      x0_q   <= x0s;
      neg_q  <= dxs[OpW-1];
      mag_q  <= dxs[OpW-1] ? OpW'(-dxs) : OpW'(dxs);
      mplr_q <= OpW'(tw);
      dy_q   <= OpW'(dyw);
      acc_q  <= '0;
    end else if (cmd_i.mul_step) begin
      acc_q  <= {acc_q[ppit_pkg::ProdW-2:0], 1'b0} +
                (mplr_q[OpW-1] ? {{OpW{1'b0}}, mag_q} : '0);
      mplr_q <= {mplr_q[OpW-2:0], 1'b0};
    end else if (cmd_i.div_step) begin
      acc_q <= {nr[OpW-1:0], acc_q[OpW-2:0], ge};
    end
    if (cmd_i.out_load) begin
      inside_res_o     <= count_q[0];
      crossing_count_o <= count_q;
      overflow_o       <= cmd_i.ovf;
    end
  end

endmodule

@@ rtl/core/polygon_point_inside_test_top.sv @@
// load and clear items are accepted in StIdle; the block is ready again the next cycle
// a query steps through StRead, StLoad and StNext for each vertex, and each
// straddling edge also passes the serial 33-step multiplier and 33-step divider
// one query at a time: in_stall_o stays high until the query result is loaded
// reset (async, active low) empties the vertex store and clears the overflow flag
module polygon_point_inside_test_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         kind_i,
  input  logic signed [ppit_pkg::CoordW-1:0] vert_x_i,
  input  logic signed [ppit_pkg::CoordW-1:0] vert_y_i,
  input  logic                               ring_last_i,
  input  logic signed [ppit_pkg::QueryW-1:0] query_x_i,
  input  logic signed [ppit_pkg::QueryW-1:0] query_y_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               inside_res_o,
  output logic [ppit_pkg::OutCntW-1:0]       crossing_count_o,
  output logic                               overflow_o
);

  logic                       wr_en, rd_en;
  logic [ppit_pkg::AddrW-1:0] wr_addr, rd_addr;
  ppit_pkg::vert_t            wr_data, rd_data;
  ppit_pkg::cmd_t             cmd;
  ppit_pkg::sts_t             sts;

  assign wr_data.last = ring_last_i;
  assign wr_data.y    = vert_y_i;
  assign wr_data.x    = vert_x_i;

  ppit_ram #(
    .Width(ppit_pkg::VertW),
    .Depth(ppit_pkg::MaxVerts)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ppit_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ppit_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .query_x_i        (query_x_i),
    .query_y_i        (query_y_i),
    .rd_data_i        (rd_data),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .inside_res_o     (inside_res_o),
    .crossing_count_o (crossing_count_o),
    .overflow_o       (overflow_o)
  );

endmodule

@@ rtl/core/ppit_checker.sv @@
`include "polygon_point_inside_test_top_defines.svh"

module ppit_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic [1:0]                         kind_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic                               inside_res_o,
  input logic [ppit_pkg::OutCntW-1:0]       crossing_count_o,
  input logic                               overflow_o
);

  `PPIT_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(crossing_count_o) && $stable(inside_res_o) && $stable(overflow_o))
  `PPIT_ASSERT(a_parity, out_valid_o |-> inside_res_o == crossing_count_o[0])
  `PPIT_ASSERT_NEXT(a_query_busy, in_valid_i && !in_stall_o && kind_i == ppit_pkg::KindQuery, in_stall_o)
  `PPIT_ASSERT_NEXT(a_load_free, in_valid_i && !in_stall_o && kind_i != ppit_pkg::KindQuery, !in_stall_o)

endmodule

bind polygon_point_inside_test_top ppit_checker u_ppit_checker (.*);
